// ===== rtl/pvp_pkg.sv =====
// Shared types, widths, screen constants and the sine table for the vertex projection block.
// No dependencies; every module of the block imports it.
`default_nettype none

package pvp_pkg;

    localparam int SCREEN_WIDTH     = 1280;
    localparam int SCREEN_HEIGHT    = 720;
    localparam int SINE_TABLE_DEPTH = 1024;

    localparam int CENTRE_X = SCREEN_WIDTH / 2;
    localparam int CENTRE_Y = SCREEN_HEIGHT / 2;

    // rotated coordinates, magnitudes stay below 2^36
    localparam int VW    = 40;
    localparam int PW    = VW + 16;      // product of a coordinate and a trig value
    localparam int NUM_W = VW + 32;      // |lateral| times focal scale
    localparam int DEN_W = VW + 16;      // |depth| times 65536
    localparam int QBITS = 17;           // quotients at or above 2^17 saturate anyway

    localparam int IDX_W  = $clog2(SINE_TABLE_DEPTH);
    localparam int PROD_W = 16 + $clog2(SINE_TABLE_DEPTH + 1);

    localparam logic [2:0] CFG_CAM_X = 3'd0;
    localparam logic [2:0] CFG_CAM_Y = 3'd1;
    localparam logic [2:0] CFG_CAM_Z = 3'd2;
    localparam logic [2:0] CFG_ROLL  = 3'd3;
    localparam logic [2:0] CFG_PITCH = 3'd4;
    localparam logic [2:0] CFG_YAW   = 3'd5;
    localparam logic [2:0] CFG_FOCAL = 3'd6;

    typedef struct packed {
        logic signed [15:0] sin;
        logic signed [15:0] cos;
    } trig_pair_t;

    typedef struct packed {
        trig_pair_t roll;
        trig_pair_t pitch;
        trig_pair_t yaw;
    } trig_set_t;

    // control that rides along with each divider lane
    typedef struct packed {
        logic valid;
        logic zero;    // rotated depth is zero
        logic flip;    // lateral and depth share a sign: subtract from centre
        logic neg;     // lateral component is negative
    } side_t;

    typedef logic signed [15:0] sine_tab_t [SINE_TABLE_DEPTH];

    localparam logic [63:0] PI_Q30 = 64'd3373259426;

    function automatic logic signed [15:0] sine_entry(input logic [63:0] i);
        logic [63:0]        x;
        logic [63:0]        x2;
        logic [63:0]        t;
        logic signed [63:0] s;
        logic [63:0]        r;
        logic               neg;
        x   = (i * (64'd2 * PI_Q30) + 64'(SINE_TABLE_DEPTH / 2)) / 64'(SINE_TABLE_DEPTH);
        neg = 1'b0;
        if (x > PI_Q30) begin
            x   = x - PI_Q30;
            neg = 1'b1;
        end
        if (x > (PI_Q30 >> 1)) begin
            x = (x > PI_Q30) ? 64'd0 : PI_Q30 - x;
        end
        x2 = (x * x) >> 30;
        t  = x;
        s  = $signed(x);
        t  = ((t * x2) >> 30) / 64'd6;   s = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd20;  s = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd42;  s = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd72;  s = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd110; s = s - $signed(t);
        t  = ((t * x2) >> 30) / 64'd156; s = s + $signed(t);
        t  = ((t * x2) >> 30) / 64'd210; s = s - $signed(t);
        if (s < 0) begin
            s = 64'sd0;
        end
        r = ($unsigned(s) + 64'd16384) >> 15;
        if (r > 64'd32767) begin
            r = 64'd32767;
        end
        return neg ? -$signed(r[15:0]) : $signed(r[15:0]);
    endfunction

    function automatic sine_tab_t build_sine_tab();
        sine_tab_t tab;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++) begin
            tab[i] = sine_entry(64'(i));
        end
        return tab;
    endfunction

    localparam sine_tab_t SINE_TAB = build_sine_tab();

endpackage

`default_nettype wire

// ===== rtl/pvp_trig.sv =====
// Sine/cosine fetch: a sine ROM with registered read and a six-step sequencer that refreshes
// the trig registers after reset and after each angle write. Depends on pvp_pkg.
`default_nettype none

module pvp_trig (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              refresh,
    input  wire logic [15:0]       angle_roll,
    input  wire logic [15:0]       angle_pitch,
    input  wire logic [15:0]       angle_yaw,
    output pvp_pkg::trig_set_t     trig,
    output logic                   busy
);
    import pvp_pkg::*;

    localparam logic [2:0] SLOT_ROLL_SIN  = 3'd0;
    localparam logic [2:0] SLOT_ROLL_COS  = 3'd1;
    localparam logic [2:0] SLOT_PITCH_SIN = 3'd2;
    localparam logic [2:0] SLOT_PITCH_COS = 3'd3;
    localparam logic [2:0] SLOT_YAW_SIN   = 3'd4;
    localparam logic [2:0] SLOT_YAW_COS   = 3'd5;

    logic [2:0]         step_reg, step_next;
    logic               busy_reg, busy_next;
    logic               rd_vld_reg;
    logic [2:0]         rd_slot_reg;
    logic signed [15:0] rom_q_reg;
    trig_set_t          trig_reg;

    logic [15:0]        angle;
    logic [PROD_W-1:0]  idx_prod;
    logic [IDX_W-1:0]   rom_idx;

    always_comb begin
        unique case (step_reg)
            SLOT_ROLL_SIN:  angle = angle_roll;
            SLOT_ROLL_COS:  angle = angle_roll + 16'h4000;
            SLOT_PITCH_SIN: angle = angle_pitch;
            SLOT_PITCH_COS: angle = angle_pitch + 16'h4000;
            SLOT_YAW_SIN:   angle = angle_yaw;
            SLOT_YAW_COS:   angle = angle_yaw + 16'h4000;
            default:        angle = 16'h0000;
        endcase
        idx_prod = PROD_W'(angle) * PROD_W'(SINE_TABLE_DEPTH);
        rom_idx  = idx_prod[16 +: IDX_W];
    end

    always_comb begin
        step_next = step_reg;
        busy_next = busy_reg;
        if (refresh) begin
            step_next = SLOT_ROLL_SIN;
            busy_next = 1'b1;
        end else if (busy_reg) begin
            step_next = step_reg + 3'd1;
            if (step_reg == SLOT_YAW_COS) begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg   <= SLOT_ROLL_SIN;
            busy_reg   <= 1'b1;
            rd_vld_reg <= 1'b0;
        end else begin
            step_reg   <= step_next;
            busy_reg   <= busy_next;
            rd_vld_reg <= busy_reg;
        end
    end

    always_ff @(posedge aclk) begin
        rom_q_reg   <= SINE_TAB[rom_idx];
        rd_slot_reg <= step_reg;
        if (rd_vld_reg) begin
            unique case (rd_slot_reg)
                SLOT_ROLL_SIN:  trig_reg.roll.sin  <= rom_q_reg;
                SLOT_ROLL_COS:  trig_reg.roll.cos  <= rom_q_reg;
                SLOT_PITCH_SIN: trig_reg.pitch.sin <= rom_q_reg;
                SLOT_PITCH_COS: trig_reg.pitch.cos <= rom_q_reg;
                SLOT_YAW_SIN:   trig_reg.yaw.sin   <= rom_q_reg;
                SLOT_YAW_COS:   trig_reg.yaw.cos   <= rom_q_reg;
                default:        ;
            endcase
        end
    end

    assign trig = trig_reg;
    assign busy = busy_reg | rd_vld_reg;

    a_refresh_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        refresh |=> busy)
        else $error("trig refresh did not raise busy");

    a_slot_range: assert property (@(posedge aclk) disable iff (!aresetn)
        rd_vld_reg |-> (rd_slot_reg <= SLOT_YAW_COS))
        else $error("trig read slot out of range");

endmodule

`default_nettype wire

// ===== rtl/pvp_rot.sv =====
// One Euler rotation pair over two stages: products, then sum with Q15 rounding.
// o1 = s*a + c*b, o2 = c*a - s*b; a side coordinate travels along. Depends on pvp_pkg.
`default_nettype none

module pvp_rot (
    input  wire logic                   aclk,
    input  wire logic                   aresetn,
    input  wire logic                   en,
    input  wire logic                   in_valid,
    input  wire logic signed [pvp_pkg::VW-1:0] a,
    input  wire logic signed [pvp_pkg::VW-1:0] b,
    input  wire logic signed [pvp_pkg::VW-1:0] side_in,
    input  pvp_pkg::trig_pair_t         tp,
    output logic                        out_valid,
    output logic signed [pvp_pkg::VW-1:0] o1,
    output logic signed [pvp_pkg::VW-1:0] o2,
    output logic signed [pvp_pkg::VW-1:0] side_out
);
    import pvp_pkg::*;

    logic signed [PW-1:0] p_sa_reg, p_cb_reg, p_ca_reg, p_sb_reg;
    logic signed [VW-1:0] side_a_reg, side_b_reg;
    logic signed [VW-1:0] o1_reg, o2_reg;
    logic                 vld_a_reg, vld_b_reg;
    logic signed [PW:0]   sum1, sum2;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            vld_a_reg <= 1'b0;
            vld_b_reg <= 1'b0;
        end else if (en) begin
            vld_a_reg <= in_valid;
            vld_b_reg <= vld_a_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            p_sa_reg   <= a * tp.sin;
            p_cb_reg   <= b * tp.cos;
            p_ca_reg   <= a * tp.cos;
            p_sb_reg   <= b * tp.sin;
            side_a_reg <= side_in;
            o1_reg     <= sum1[15 +: VW];
            o2_reg     <= sum2[15 +: VW];
            side_b_reg <= side_a_reg;
        end
    end

    // add half an LSB, then floor by the arithmetic shift
    always_comb begin
        sum1 = (PW+1)'(p_sa_reg) + (PW+1)'(p_cb_reg) + (PW+1)'(16384);
        sum2 = (PW+1)'(p_ca_reg) - (PW+1)'(p_sb_reg) + (PW+1)'(16384);
    end

    assign out_valid = vld_b_reg;
    assign o1        = o1_reg;
    assign o2        = o2_reg;
    assign side_out  = side_b_reg;

endmodule

`default_nettype wire

// ===== rtl/pvp_div.sv =====
// Pipelined restoring divider: an overflow stage, then one quotient bit per stage.
// Gives the quotient, an overflow flag and the round-half bit. Depends on pvp_pkg.
`default_nettype none

module pvp_div (
    input  wire logic                       aclk,
    input  wire logic                       aresetn,
    input  wire logic                       en,
    input  wire logic [pvp_pkg::NUM_W-1:0]  num,
    input  wire logic [pvp_pkg::DEN_W-1:0]  den,
    input  pvp_pkg::side_t                  side_in,
    output logic [pvp_pkg::QBITS-1:0]       quo,
    output logic                            ovf,
    output logic                            half,
    output pvp_pkg::side_t                  side_out
);
    import pvp_pkg::*;

    logic [NUM_W-1:0] rem_reg  [QBITS+1];
    logic [DEN_W-1:0] den_reg  [QBITS+1];
    logic [QBITS-1:0] q_reg    [QBITS+1];
    logic             ovf_reg  [QBITS+1];
    side_t            side_reg [QBITS+1];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            side_reg[0] <= '0;
        end else if (en) begin
            side_reg[0] <= side_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg[0] <= num;
            den_reg[0] <= den;
            q_reg[0]   <= '0;
            ovf_reg[0] <= {1'b0, num} >= {den, {QBITS{1'b0}}};
        end
    end

    for (genvar k = 1; k <= QBITS; k++) begin : g_step
        localparam int SH = QBITS - k;
        logic [NUM_W-1:0] trial;
        logic             ge;

        assign trial = NUM_W'(den_reg[k-1]) << SH;
        assign ge    = rem_reg[k-1] >= trial;

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                side_reg[k] <= '0;
            end else if (en) begin
                side_reg[k] <= side_reg[k-1];
            end
        end

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k] <= ge ? rem_reg[k-1] - trial : rem_reg[k-1];
                den_reg[k] <= den_reg[k-1];
                q_reg[k]   <= {q_reg[k-1][QBITS-2:0], ge};
                ovf_reg[k] <= ovf_reg[k-1];
            end
        end
    end

    assign quo      = q_reg[QBITS];
    assign ovf      = ovf_reg[QBITS];
    assign half     = {rem_reg[QBITS][DEN_W-1:0], 1'b0} >= {1'b0, den_reg[QBITS]};
    assign side_out = side_reg[QBITS];

endmodule

`default_nettype wire

// ===== rtl/perspective_vertex_projection.sv =====
// One vertex per cycle while the output is not stalled and the trig unit is not busy.
// Throughput is set by the fully pipelined rotation and divider lanes; a stalled output holds
// the whole pipeline. After reset and after each angle write the trig unit reads its sine ROM,
// during which s_tready is low. Reset (aresetn low, synchronous) restores the camera
// registers and empties the pipeline. Depends on pvp_pkg, pvp_trig, pvp_rot, pvp_div.
`default_nettype none

module perspective_vertex_projection (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [95:0] s_tdata,   // vertex_x, vertex_y, vertex_z
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [31:0]      m_tdata,   // screen_x, screen_y
    output logic             m_tuser,   // zero_depth
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [31:0] cfg_data
);
    import pvp_pkg::*;

    logic signed [31:0] cam_x_reg, cam_y_reg, cam_z_reg;
    logic [15:0]        roll_reg, pitch_reg, yaw_reg;
    logic [31:0]        focal_reg;

    logic      cfg_we, refresh, trig_busy, adv, s_beat;
    trig_set_t trig;

    assign cfg_ready = 1'b1;
    assign cfg_we    = cfg_valid && cfg_ready;
    assign refresh   = cfg_we && (cfg_index == CFG_ROLL || cfg_index == CFG_PITCH
                                  || cfg_index == CFG_YAW);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cam_x_reg <= 32'sd327680;
            cam_y_reg <= 32'sd327680;
            cam_z_reg <= 32'sd327680;
            roll_reg  <= 16'd0;
            pitch_reg <= 16'd49152;
            yaw_reg   <= 16'd0;
            focal_reg <= 32'd26214400;
        end else if (cfg_we) begin
            unique case (cfg_index)
                CFG_CAM_X: cam_x_reg <= cfg_data;
                CFG_CAM_Y: cam_y_reg <= cfg_data;
                CFG_CAM_Z: cam_z_reg <= cfg_data;
                CFG_ROLL:  roll_reg  <= cfg_data[15:0];
                CFG_PITCH: pitch_reg <= cfg_data[15:0];
                CFG_YAW:   yaw_reg   <= cfg_data[15:0];
                CFG_FOCAL: focal_reg <= cfg_data;
                default:   ;
            endcase
        end
    end

    pvp_trig u_trig (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .refresh     (refresh),
        .angle_roll  (roll_reg),
        .angle_pitch (pitch_reg),
        .angle_yaw   (yaw_reg),
        .trig        (trig),
        .busy        (trig_busy)
    );

    // whole pipeline advances whenever the output register can take a beat
    assign adv      = !m_tvalid || m_tready;
    assign s_tready = adv && !trig_busy;
    assign s_beat   = s_tvalid && s_tready;

    // camera-relative vertex
    logic signed [31:0] vx, vy, vz;
    logic signed [VW-1:0] cx_reg, cy_reg, cz_reg;
    logic                 v1_reg;

    assign vx = s_tdata[31:0];
    assign vy = s_tdata[63:32];
    assign vz = s_tdata[95:64];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_beat;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            cx_reg <= VW'(vx) - VW'(cam_x_reg);
            cy_reg <= VW'(vy) - VW'(cam_y_reg);
            cz_reg <= VW'(vz) - VW'(cam_z_reg);
        end
    end

    logic                 v_yaw, v_pitch, v_roll;
    logic signed [VW-1:0] u, w, cz_d, p, dx, w_d, dy, dz, dx_d;

    pvp_rot u_yaw (
        .aclk (aclk), .aresetn (aresetn), .en (adv), .in_valid (v1_reg),
        .a (cy_reg), .b (cx_reg), .side_in (cz_reg), .tp (trig.yaw),
        .out_valid (v_yaw), .o1 (u), .o2 (w), .side_out (cz_d)
    );

    pvp_rot u_pitch (
        .aclk (aclk), .aresetn (aresetn), .en (adv), .in_valid (v_yaw),
        .a (u), .b (cz_d), .side_in (w), .tp (trig.pitch),
        .out_valid (v_pitch), .o1 (p), .o2 (dx), .side_out (w_d)
    );

    pvp_rot u_roll (
        .aclk (aclk), .aresetn (aresetn), .en (adv), .in_valid (v_pitch),
        .a (p), .b (w_d), .side_in (dx), .tp (trig.roll),
        .out_valid (v_roll), .o1 (dy), .o2 (dz), .side_out (dx_d)
    );

    // magnitudes and signs
    logic [VW-1:0] ax_reg, ay_reg, az_reg;
    side_t         sx8_reg, sy8_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx8_reg <= '0;
            sy8_reg <= '0;
        end else if (adv) begin
            sx8_reg <= '{valid: v_roll, zero: dz == '0, flip: dx_d[VW-1] == dz[VW-1],
                         neg: dx_d[VW-1]};
            sy8_reg <= '{valid: v_roll, zero: dz == '0, flip: dy[VW-1] == dz[VW-1],
                         neg: dy[VW-1]};
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ax_reg <= dx_d[VW-1] ? $unsigned(-dx_d) : $unsigned(dx_d);
            ay_reg <= dy[VW-1]   ? $unsigned(-dy)   : $unsigned(dy);
            az_reg <= dz[VW-1]   ? $unsigned(-dz)   : $unsigned(dz);
        end
    end

    // split products of the magnitude and the focal scale
    localparam int HALF = VW / 2;
    localparam int PP_W = HALF + 32;

    logic [PP_W-1:0] x_lo_reg, x_hi_reg, y_lo_reg, y_hi_reg;
    logic [VW-1:0]   az9_reg;
    side_t           sx9_reg, sy9_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx9_reg <= '0;
            sy9_reg <= '0;
        end else if (adv) begin
            sx9_reg <= sx8_reg;
            sy9_reg <= sy8_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            x_lo_reg <= PP_W'(ax_reg[HALF-1:0]) * PP_W'(focal_reg);
            x_hi_reg <= PP_W'(ax_reg[VW-1:HALF]) * PP_W'(focal_reg);
            y_lo_reg <= PP_W'(ay_reg[HALF-1:0]) * PP_W'(focal_reg);
            y_hi_reg <= PP_W'(ay_reg[VW-1:HALF]) * PP_W'(focal_reg);
            az9_reg  <= az_reg;
        end
    end

    logic [NUM_W-1:0] nx_reg, ny_reg;
    logic [DEN_W-1:0] den_reg;
    side_t            sx10_reg, sy10_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sx10_reg <= '0;
            sy10_reg <= '0;
        end else if (adv) begin
            sx10_reg <= sx9_reg;
            sy10_reg <= sy9_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            nx_reg  <= NUM_W'(x_lo_reg) + {x_hi_reg, {HALF{1'b0}}};
            ny_reg  <= NUM_W'(y_lo_reg) + {y_hi_reg, {HALF{1'b0}}};
            den_reg <= {az9_reg, 16'h0000};
        end
    end

    logic [QBITS-1:0] qx, qy;
    logic             ovf_x, ovf_y, half_x, half_y;
    side_t            sxo, syo;

    pvp_div u_div_x (
        .aclk (aclk), .aresetn (aresetn), .en (adv),
        .num (nx_reg), .den (den_reg), .side_in (sx10_reg),
        .quo (qx), .ovf (ovf_x), .half (half_x), .side_out (sxo)
    );

    pvp_div u_div_y (
        .aclk (aclk), .aresetn (aresetn), .en (adv),
        .num (ny_reg), .den (den_reg), .side_in (sy10_reg),
        .quo (qy), .ovf (ovf_y), .half (half_y), .side_out (syo)
    );

    // rounding, sign, centre offset and saturation
    function automatic logic signed [15:0] place(input logic [QBITS-1:0] q,
                                                 input logic ovf_in, input logic half_in,
                                                 input side_t sd, input logic [11:0] centre);
        logic [QBITS:0]       qr;
        logic signed [QBITS+2:0] v;
        qr = ovf_in ? (QBITS+1)'(1) << QBITS : (QBITS+1)'(q) + (QBITS+1)'(half_in);
        v  = sd.flip ? (QBITS+3)'(centre) - (QBITS+3)'(qr)
                     : (QBITS+3)'(centre) + (QBITS+3)'(qr);
        if (sd.zero) begin
            return sd.neg ? 16'sh7fff : 16'sh8000;
        end
        if (v > (QBITS+3)'(32767)) begin
            return 16'sh7fff;
        end
        if (v < -(QBITS+3)'(32768)) begin
            return 16'sh8000;
        end
        return v[15:0];
    endfunction

    logic [31:0] m_tdata_reg;
    logic        m_tuser_reg, m_tvalid_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (adv) begin
            m_tvalid_reg <= sxo.valid && syo.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg[15:0]  <= place(qx, ovf_x, half_x, sxo, 12'(CENTRE_X));
            m_tdata_reg[31:16] <= place(qy, ovf_y, half_y, syo, 12'(CENTRE_Y));
            m_tuser_reg        <= sxo.zero;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    a_angle_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        refresh |=> !s_tready)
        else $error("input accepted while trig values refresh");

    a_zero_saturates: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser) |-> ((m_tdata[15:0] == 16'h7fff || m_tdata[15:0] == 16'h8000)
                                   && (m_tdata[31:16] == 16'h7fff
                                       || m_tdata[31:16] == 16'h8000)))
        else $error("zero depth result not saturated");

    a_reset_empties: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

endmodule

`default_nettype wire

// ===== sim/perspective_vertex_projection_tb.sv =====
// Testbench for perspective_vertex_projection: directed and random vertex beats
// checked against a bit-accurate projection predictor. Depends on pvp_pkg and the RTL.
`default_nettype none

module perspective_vertex_projection_tb;
    import pvp_pkg::*;

    localparam int      LATENCY = 29;
    localparam int      MAX_GAP = 12;
    localparam longint  LIMIT   = 1000000;
    localparam longint  QCAP    = 64'd1 << 24;
    localparam logic [2:0] CFG_NONE = 3'd7;   // index past the register list

    typedef struct packed {
        logic signed [15:0] px;
        logic signed [15:0] py;
        logic               zero_depth;
    } pixel_t;

    logic        aclk;
    logic        aresetn;
    logic        s_tvalid;
    logic        s_tready;
    logic [95:0] s_tdata;    // vertex_x, vertex_y, vertex_z
    logic        m_tvalid;
    logic        m_tready;
    logic [31:0] m_tdata;    // screen_x, screen_y
    logic        m_tuser;    // zero_depth
    logic        cfg_valid;
    logic        cfg_ready;
    logic [2:0]  cfg_index;
    logic [31:0] cfg_data;

    perspective_vertex_projection u_top (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    // predictor copy of the camera registers
    logic signed [31:0] cam_x, cam_y, cam_z;
    logic [15:0]        ang_roll, ang_pitch, ang_yaw;
    logic [31:0]        focal;
    longint             sine_rom_q15 [SINE_TABLE_DEPTH];

    pixel_t  pixel_q[$];
    int      errors;
    longint  cycles;
    int      beats_out;
    bit      tx_idle_on;
    bit      rx_idle_on;

    function automatic longint sine_q15(longint unsigned i);
        longint unsigned x, x2, t, r;
        longint          s;
        bit              neg;
        x   = (i * (64'd2 * 64'd3373259426) + SINE_TABLE_DEPTH / 2) / SINE_TABLE_DEPTH;
        neg = 0;
        if (x > 64'd3373259426) begin
            x   = x - 64'd3373259426;
            neg = 1;
        end
        if (x > 64'd3373259426 / 2)
            x = (x > 64'd3373259426) ? 0 : 64'd3373259426 - x;
        x2 = (x * x) >> 30;
        t  = x;
        s  = longint'(x);
        for (int k = 1; k <= 7; k++) begin
            t = ((t * x2) >> 30) / ((2 * k) * (2 * k + 1));
            if (k % 2 == 1) s = s - longint'(t);
            else            s = s + longint'(t);
        end
        if (s < 0) s = 0;
        r = (longint'(s) + 16384) >> 15;
        if (r > 32767) r = 32767;
        return neg ? -longint'(r) : longint'(r);
    endfunction

    function automatic longint sin_of(logic [15:0] a);
        longint idx;
        idx = (longint'(a) * SINE_TABLE_DEPTH) >>> 16;
        if (idx >= SINE_TABLE_DEPTH) idx = SINE_TABLE_DEPTH - 1;
        return sine_rom_q15[idx];
    endfunction

    // floor((x + 2^14) / 2^15)
    function automatic longint round_q15(longint x);
        return (x + 16384) >>> 15;
    endfunction

    function automatic logic signed [15:0] lateral_to_pixel(longint d, longint z, longint centre);
        logic [127:0] num, den, q, rem;
        longint       v;
        num = 128'(d < 0 ? -d : d) * 128'(focal);
        den = 128'(z < 0 ? -z : z) << 16;
        q   = num / den;
        rem = num % den;
        if (q >= QCAP)          q = QCAP;
        else if (2 * rem >= den) q = q + 1;
        v = ((d < 0) == (z < 0)) ? centre - longint'(q) : centre + longint'(q);
        if (v > 32767)  v = 32767;
        if (v < -32768) v = -32768;
        return 16'(v);
    endfunction

    function automatic pixel_t project_vertex(logic [95:0] vtx);
        longint cx, cy, cz, sr, cr, sp, cp, sw, cw, u, w, p, dx, dy, dz;
        pixel_t res;
        cx = longint'($signed(vtx[31:0]))  - longint'(cam_x);
        cy = longint'($signed(vtx[63:32])) - longint'(cam_y);
        cz = longint'($signed(vtx[95:64])) - longint'(cam_z);
        sr = sin_of(ang_roll);  cr = sin_of(ang_roll + 16'd16384);
        sp = sin_of(ang_pitch); cp = sin_of(ang_pitch + 16'd16384);
        sw = sin_of(ang_yaw);   cw = sin_of(ang_yaw + 16'd16384);
        u  = round_q15(sw * cy + cw * cx);
        w  = round_q15(cw * cy - sw * cx);
        p  = round_q15(cp * cz + sp * u);
        dx = round_q15(cp * u - sp * cz);
        dy = round_q15(sr * p + cr * w);
        dz = round_q15(cr * p - sr * w);
        if (dz == 0) begin
            res.zero_depth = 1'b1;
            res.px = (dx < 0) ? 16'sd32767 : -16'sd32768;
            res.py = (dy < 0) ? 16'sd32767 : -16'sd32768;
        end else begin
            res.zero_depth = 1'b0;
            res.px = lateral_to_pixel(dx, dz, CENTRE_X);
            res.py = lateral_to_pixel(dy, dz, CENTRE_Y);
        end
        return res;
    endfunction

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("** perspective_vertex_projection: FAILED **");
            $finish;
        end
    end

    // result checker
    always @(posedge aclk) begin
        pixel_t want;
        if (aresetn && m_tvalid && m_tready) begin
            beats_out <= beats_out + 1;
            if (pixel_q.size() == 0) begin
                $display("%0t: unexpected beat x=%0d y=%0d zero=%0b", $time,
                         $signed(m_tdata[15:0]), $signed(m_tdata[31:16]), m_tuser);
                errors = errors + 1;
            end else begin
                want = pixel_q.pop_front();
                if (m_tdata[15:0] !== want.px) begin
                    $display("%0t: screen_x expected %0d got %0d", $time, want.px,
                             $signed(m_tdata[15:0]));
                    errors = errors + 1;
                end
                if (m_tdata[31:16] !== want.py) begin
                    $display("%0t: screen_y expected %0d got %0d", $time, want.py,
                             $signed(m_tdata[31:16]));
                    errors = errors + 1;
                end
                if (m_tuser !== want.zero_depth) begin
                    $display("%0t: zero_depth expected %0b got %0b", $time,
                             want.zero_depth, m_tuser);
                    errors = errors + 1;
                end
            end
        end
    end

    // receiver stalls: fresh draw after every taken beat
    initial begin
        int seen;
        int stall;
        seen  = 0;
        stall = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (beats_out != seen) begin
                seen  = beats_out;
                stall = rx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
            end
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
            end
        end
    end

    task automatic send_vertex(logic [31:0] vx, logic [31:0] vy, logic [31:0] vz);
        int gap;
        gap = tx_idle_on ? $urandom_range(0, MAX_GAP) : 0;
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tdata  = {vz, vy, vx};
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pixel_q.insert(pixel_q.size(), project_vertex(s_tdata));
        @(negedge aclk);
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        wait (pixel_q.size() == 0);
        repeat (LATENCY + 8) @(negedge aclk);
    endtask

    task automatic write_reg(logic [2:0] idx, logic [31:0] val);
        cfg_index = idx;
        cfg_data  = val;
        cfg_valid = 1'b1;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_CAM_X: cam_x     = val;
            CFG_CAM_Y: cam_y     = val;
            CFG_CAM_Z: cam_z     = val;
            CFG_ROLL:  ang_roll  = val[15:0];
            CFG_PITCH: ang_pitch = val[15:0];
            CFG_YAW:   ang_yaw   = val[15:0];
            CFG_FOCAL: focal     = val;
            default: ;
        endcase
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic set_camera(logic [31:0] x, logic [31:0] y, logic [31:0] z,
                              logic [15:0] roll, logic [15:0] pitch, logic [15:0] yaw,
                              logic [31:0] f);
        write_reg(CFG_CAM_X, x);
        write_reg(CFG_CAM_Y, y);
        write_reg(CFG_CAM_Z, z);
        write_reg(CFG_ROLL, {16'h0, roll});
        write_reg(CFG_PITCH, {16'h0, pitch});
        write_reg(CFG_YAW, {16'h0, yaw});
        write_reg(CFG_FOCAL, f);
    endtask

    function automatic logic [31:0] near(logic [31:0] c, int span);
        return c + 32'($signed($urandom_range(0, 2 * span)) - span);
    endfunction

    // one random vertex: mostly within 2^20 or 2^24 of the camera on each axis, some raw noise,
    // some on or next to the camera itself (zero and tiny depth)
    task automatic send_random_vertex();
        int kind;
        kind = $urandom_range(0, 99);
        if (kind < 10)
            send_vertex(cam_x, cam_y, cam_z);
        else if (kind < 20)
            send_vertex(near(cam_x, 2), near(cam_y, 2), near(cam_z, 2));
        else if (kind < 35)
            send_vertex($urandom, $urandom, $urandom);
        else if (kind < 60)
            send_vertex(near(cam_x, 1 << 24), near(cam_y, 1 << 24), near(cam_z, 1 << 24));
        else
            send_vertex(near(cam_x, 1 << 20), near(cam_y, 1 << 20), near(cam_z, 1 << 20));
    endtask

    task automatic test_reset_defaults();
        // default view: depth is -(x - cam_x), so x on the camera plane gives zero depth
        send_vertex(32'd327680, 32'd327680, 32'd327680);
        send_vertex(32'd327680, 32'd0, 32'd0);
        send_vertex(32'd327680, 32'd655360, 32'd655360);
        send_vertex(32'd0, 32'd327680, 32'd327680);
        send_vertex(32'd0, 32'd0, 32'd0);
        send_vertex(32'd983040, 32'd393216, 32'd262144);   // negative depth, mirrored
        send_vertex(32'd327679, 32'h7FFF_FFFF, 32'h8000_0000);
        send_vertex(32'd327681, 32'h0100_0000, 32'd327680);
    endtask

    task automatic test_field_extremes();
        logic [31:0] ext [4];
        ext = '{32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'hFFFF_FFFF};
        for (int i = 0; i < 4; i++)
            for (int j = 0; j < 4; j += 3)
                send_vertex(ext[i], ext[(i + j) % 4], ext[(i + 1) % 4]);
        send_vertex(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_vertex(32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555);
        send_vertex(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA);
    endtask

    task automatic test_config_extremes();
        drain();
        write_reg(CFG_NONE, 32'hFFFF_FFFF);
        set_camera(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 16'hFFFF, 16'h0, 16'hFFFF,
                   32'hFFFF_FFFF);
        repeat (10) send_random_vertex();
        drain();
        set_camera(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 16'h0, 16'hFFFF, 16'h0,
                   32'h0);
        repeat (10) send_random_vertex();
        drain();
        set_camera(32'h0, 32'h0, 32'h0, 16'h4000, 16'h8000, 16'hC000, 32'h0001_0000);
        repeat (10) send_random_vertex();
        drain();
        set_camera(32'hFFFF_0000, 32'h0002_0000, 32'h0, 16'h2000, 16'h1000, 16'h0FC0,
                   32'h0000_0001);
        repeat (10) send_random_vertex();
        drain();
        set_camera(32'h0, 32'h0, 32'h0, 16'h0, 16'hC000, 16'h0, 32'h8000_0000);
        repeat (10) send_random_vertex();
        drain();
    endtask

    task automatic test_random_views();
        for (int v = 0; v < 8; v++) begin
            if (v % 3 == 0)
                set_camera(near(32'd0, 1 << 22), near(32'd0, 1 << 22), near(32'd0, 1 << 22),
                           16'h0, 16'hC000, 16'h0, $urandom_range(1 << 20, 1 << 28));
            else
                set_camera($urandom, $urandom, $urandom, 16'($urandom), 16'($urandom),
                           16'($urandom), $urandom);
            tx_idle_on = (v % 4 != 1);
            rx_idle_on = (v % 4 != 2);
            for (int i = 0; i < 170; i++) begin
                send_random_vertex();
                if (i == 85 && v == 3) begin
                    // hold the sender until the pipeline has emptied
                    s_tvalid = 1'b0;
                    wait (pixel_q.size() == 0);
                    @(negedge aclk);
                end
            end
            drain();
        end
    endtask

    initial begin
        errors     = 0;
        cycles     = 0;
        beats_out  = 0;
        tx_idle_on = 1'b1;
        rx_idle_on = 1'b1;
        aresetn    = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        cfg_valid  = 1'b0;
        cfg_index  = CFG_CAM_X;
        cfg_data   = '0;
        cam_x      = 32'sd327680;
        cam_y      = 32'sd327680;
        cam_z      = 32'sd327680;
        ang_roll   = 16'd0;
        ang_pitch  = 16'd49152;
        ang_yaw    = 16'd0;
        focal      = 32'd26214400;
        for (int i = 0; i < SINE_TABLE_DEPTH; i++)
            sine_rom_q15[i] = sine_q15(i);
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        test_reset_defaults();
        test_field_extremes();
        test_config_extremes();
        test_random_views();

        drain();
        if (errors == 0)
            $display("** perspective_vertex_projection: PASSED **");
        else
            $display("** perspective_vertex_projection: FAILED **");
        $finish;
    end

endmodule

`default_nettype wire

// ===== sim.f =====
rtl/pvp_pkg.sv
rtl/pvp_trig.sv
rtl/pvp_rot.sv
rtl/pvp_div.sv
rtl/perspective_vertex_projection.sv
sim/perspective_vertex_projection_tb.sv
